@@ hdl/jdaf_pkg.sv @@
// ----------------------------------------------------------------------------
// jdaf_pkg
// shared constants, types and the sample scaling function of the joystick
// deadzone / moving-average framer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jdaf_pkg;

  // field widths
  localparam int RAW_W    = 12;   // adc sample
  localparam int VAL_W    = 9;    // scaled value, signed -255..255
  localparam int BYTE_W   = 8;
  localparam int DZ_W     = 8;    // deadzone register
  localparam int SCALED_W = 21;   // sample * span

  // scaling constants
  localparam int SCALE_SPAN     = 510;
  localparam int ADC_FULL       = 4095;  // 2**RAW_W - 1
  localparam int SCALE_OFFSET   = 255;
  localparam int DEADZONE_RESET = 30;
  localparam logic [BYTE_W-1:0] TERMINATOR = 8'hFF;

  // parameter defaults
  localparam int WINDOW_LEN_DEF = 5;
  localparam int AXIS_COUNT_DEF = 2;

  // apb port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_DEADZONE = 1'b0;  // word index of the deadzone register

  // averaged value on its way from the divider to the framer
  typedef struct packed {
    logic                    axis;
    logic signed [VAL_W-1:0] avg;
  } avg_item_t;

  // floor(raw*510/4095) - 255, then deadzone; the divide by 2**12-1 is done as
  // a shift plus one correction since the remainder stays below twice 4095
  function automatic logic signed [VAL_W-1:0] scale_sample(
    input logic [RAW_W-1:0] raw,
    input logic [DZ_W-1:0]  dz
  );
    logic [SCALED_W-1:0]       prod;
    logic [VAL_W-1:0]          q0;
    logic [RAW_W:0]            rem;
    logic [VAL_W:0]            quot;
    logic signed [VAL_W:0]     v;
    logic [DZ_W-1:0]           mag;
    prod = SCALED_W'(raw) * SCALED_W'(SCALE_SPAN);
    q0   = prod[SCALED_W-1:RAW_W];
    rem  = (RAW_W+1)'(prod[RAW_W-1:0]) + (RAW_W+1)'(q0);
    quot = (VAL_W+1)'(q0) + (VAL_W+1)'(rem >= (RAW_W+1)'(ADC_FULL));
    v    = $signed(quot) - (VAL_W+1)'(SCALE_OFFSET);
    mag  = v[VAL_W] ? DZ_W'(-v) : DZ_W'(v);
    if (mag < dz) begin
      return '0;
    end
    return v[VAL_W-1:0];
  endfunction

endpackage

@@ hdl/jdaf_if.sv @@
// ----------------------------------------------------------------------------
// jdaf channel interfaces
// valid/ready channels for the sample input and the frame byte output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface jdaf_in_if;
  logic                       valid;
  logic                       ready;
  logic                       axis;
  logic [jdaf_pkg::RAW_W-1:0] sample;

  modport source (output valid, output axis, output sample, input ready);
  modport sink   (input valid, input axis, input sample, output ready);
endinterface

interface jdaf_out_if;
  logic                        valid;
  logic                        ready;
  logic [jdaf_pkg::BYTE_W-1:0] out_byte;
  logic                        frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink   (input valid, input out_byte, input frame_end, output ready);
endinterface

@@ hdl/jdaf_cell.sv @@
// ----------------------------------------------------------------------------
// jdaf_cell
// one window position holding a value for every axis; on a push the entry of
// the selected axis takes the value of its upstream neighbor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdaf_cell #(
  parameter int AXIS_COUNT = jdaf_pkg::AXIS_COUNT_DEF,
  parameter int AXIS_IW    = 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic [AXIS_IW-1:0]                  axis_i,
  input  logic signed [jdaf_pkg::VAL_W-1:0]   val_i,
  output logic signed [jdaf_pkg::VAL_W-1:0]   val_o
);
  import jdaf_pkg::*;

  logic signed [VAL_W-1:0] entry_q [AXIS_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
        entry_q[a] <= '0;
      end
    end else if (push_i) begin
      entry_q[axis_i] <= val_i;
    end
  end

  assign val_o = entry_q[axis_i];

endmodule

@@ hdl/jdaf_div.sv @@
// ----------------------------------------------------------------------------
// jdaf_div
// two-stage divide of the window sum by the window length, truncating toward
// zero: reciprocal multiply, then one remainder correction and sign restore
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdaf_div #(
  parameter int WINDOW_LEN = jdaf_pkg::WINDOW_LEN_DEF
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   in_valid_i,
  output logic                                                   in_ready_o,
  input  logic                                                   in_axis_i,
  input  logic signed [jdaf_pkg::VAL_W+$clog2(WINDOW_LEN)-1:0]   in_sum_i,
  output logic                                                   out_valid_o,
  input  logic                                                   out_ready_i,
  output jdaf_pkg::avg_item_t                                    out_item_o
);
  import jdaf_pkg::*;

  localparam int SUM_W = VAL_W + $clog2(WINDOW_LEN);
  localparam int AW    = SUM_W - 1;               // magnitude width
  localparam int PW    = 2 * AW;
  localparam logic [AW-1:0] RECIP = AW'((1 << AW) / WINDOW_LEN);

  // stage a: magnitude and underestimated quotient
  logic             a_valid_q;
  logic             a_axis_q, a_neg_q;
  logic [AW-1:0]    a_mag_q, a_q0_q;
  logic [AW-1:0]    mag;
  logic [PW-1:0]    prod;
  logic             a_ready;

  // stage b: corrected signed average
  logic             b_valid_q;
  avg_item_t        b_item_q;
  logic             b_ready;
  logic [AW-1:0]    rem;
  logic [AW-1:0]    quot;
  logic [VAL_W-1:0] quot_n;

  assign mag  = in_sum_i[SUM_W-1] ? AW'(-in_sum_i) : AW'(in_sum_i);
  assign prod = PW'(mag) * PW'(RECIP);

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_axis_q <= in_axis_i;
      a_neg_q  <= in_sum_i[SUM_W-1];
      a_mag_q  <= mag;
      a_q0_q   <= prod[PW-1:AW];
    end
  end

  // quotient is low by at most one
  assign rem    = a_mag_q - AW'(a_q0_q * AW'(WINDOW_LEN));
  assign quot   = a_q0_q + AW'(rem >= AW'(WINDOW_LEN));
  assign quot_n = VAL_W'(quot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_item_q.axis <= a_axis_q;
      b_item_q.avg  <= a_neg_q ? -$signed(quot_n) : $signed(quot_n);
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_item_o  = b_item_q;

endmodule

@@ hdl/jdaf_framer.sv @@
// ----------------------------------------------------------------------------
// jdaf_framer
// holds one averaged value and sends it as four bytes: axis, low, high, 0xff
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdaf_framer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  jdaf_pkg::avg_item_t in_item_i,
  jdaf_out_if.source          out_o
);
  import jdaf_pkg::*;

  localparam logic [1:0] BYTE_AXIS = 2'd0;
  localparam logic [1:0] BYTE_LOW  = 2'd1;
  localparam logic [1:0] BYTE_HIGH = 2'd2;
  localparam logic [1:0] BYTE_TERM = 2'd3;

  logic       full_q, full_d;
  logic [1:0] pos_q, pos_d;
  avg_item_t  item_q;
  logic       take_byte;
  logic       load;

  assign take_byte  = full_q && out_o.ready;
  assign in_ready_o = !full_q || (take_byte && (pos_q == BYTE_TERM));
  assign load       = in_ready_o && in_valid_i;

  always_comb begin
    full_d = full_q;
    pos_d  = pos_q;
    if (take_byte) begin
      pos_d = pos_q + 2'd1;
      if (pos_q == BYTE_TERM) begin
        full_d = 1'b0;
      end
    end
    if (load) begin
      full_d = 1'b1;
      pos_d  = BYTE_AXIS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      pos_q  <= BYTE_AXIS;
    end else begin
      full_q <= full_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  always_comb begin
    out_o.frame_end = 1'b0;
    unique case (pos_q)
      BYTE_AXIS: out_o.out_byte = BYTE_W'(item_q.axis);
      BYTE_LOW:  out_o.out_byte = item_q.avg[BYTE_W-1:0];
      BYTE_HIGH: out_o.out_byte = {BYTE_W{item_q.avg[VAL_W-1]}};
      BYTE_TERM: begin
        out_o.out_byte  = TERMINATOR;
        out_o.frame_end = 1'b1;
      end
      default:   out_o.out_byte = '0;
    endcase
  end

  assign out_o.valid = full_q;

endmodule

@@ hdl/joystick_deadzone_average_framer.sv @@
// ----------------------------------------------------------------------------
// joystick_deadzone_average_framer
// scales 12-bit joystick samples to -255..255, applies a deadzone, averages
// the last samples of each axis and sends the result as a four-byte frame
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  in_i     in   valid / ready    axis (1), sample (12)
//  out_o    out  valid / ready    out_byte (8), frame_end (1)
//  apb      in   psel / penable   deadzone at byte address 0, 8 bits
//
//  an item is registered in the scale stage, the sum register (window push),
//  two divide stages and the framer before its first byte shows up; the
//  sustained rate is set by the four bytes a frame puts on the one-byte output
//  reset clears the windows, running sums and pipeline valids at once; the
//  deadzone returns to 30
//  a stall on out_o fills the pipeline stages one by one before in_i stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module joystick_deadzone_average_framer #(
  parameter int WINDOW_LEN = jdaf_pkg::WINDOW_LEN_DEF,
  parameter int AXIS_COUNT = jdaf_pkg::AXIS_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  jdaf_in_if.sink                        in_i,
  jdaf_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [jdaf_pkg::PADDR_W-1:0]   paddr,
  input  logic [jdaf_pkg::PDATA_W-1:0]   pwdata,
  output logic [jdaf_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import jdaf_pkg::*;

  localparam int SUM_W   = VAL_W + $clog2(WINDOW_LEN);
  localparam int AXIS_IW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

  // ---------------- configuration ----------------
  logic [DZ_W-1:0] deadzone_q;
  logic            reg_sel;

  // word index taken from the address; low byte-lane bits are don't care
  assign reg_sel = (paddr[2] == REG_DEADZONE);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? PDATA_W'(deadzone_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= DZ_W'(DEADZONE_RESET);
    end else if (psel && penable && pwrite && reg_sel) begin
      deadzone_q <= pwdata[DZ_W-1:0];
    end
  end

  // ---------------- stage 1: scaled, deadzoned value ----------------
  logic                    s1_valid_q;
  logic [AXIS_IW-1:0]      s1_axis_q;
  logic signed [VAL_W-1:0] s1_val_q;
  logic                    s1_adv;
  logic                    axis_ok;

  // samples for an axis beyond the configured count are taken and dropped
  assign axis_ok  = (32'(in_i.axis) < AXIS_COUNT);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid && axis_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_axis_q <= AXIS_IW'(in_i.axis);
      s1_val_q  <= scale_sample(in_i.sample, deadzone_q);
    end
  end

  // ---------------- window: chain of cells ----------------
  // tap[k] is the value held by cell k for the current axis; cell 0 is the
  // oldest and drops out on a push, the new value enters at the far end
  logic signed [VAL_W-1:0] tap [WINDOW_LEN+1];

  assign tap[WINDOW_LEN] = s1_val_q;

  for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
    jdaf_cell #(
      .AXIS_COUNT (AXIS_COUNT),
      .AXIS_IW    (AXIS_IW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .push_i (s1_adv),
      .axis_i (s1_axis_q),
      .val_i  (tap[k+1]),
      .val_o  (tap[k])
    );
  end

  // running sum per axis, kept equal to the sum of that axis's window
  logic signed [SUM_W-1:0] sum_q [AXIS_COUNT];
  logic signed [SUM_W-1:0] sum_new;

  assign sum_new = sum_q[s1_axis_q] + SUM_W'(s1_val_q) - SUM_W'(tap[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
        sum_q[a] <= '0;
      end
    end else if (s1_adv) begin
      sum_q[s1_axis_q] <= sum_new;
    end
  end

  // ---------------- stage 2: sum register toward the divider ----------------
  logic                    s2_valid_q;
  logic                    s2_axis_q;
  logic signed [SUM_W-1:0] s2_sum_q;
  logic                    s2_ready;
  logic                    div_in_ready;

  assign s2_ready = !s2_valid_q || div_in_ready;
  assign s1_adv   = s1_valid_q && s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_axis_q <= s1_axis_q[0];
      s2_sum_q  <= sum_new;
    end
  end

  // ---------------- divide by window length ----------------
  logic      div_valid;
  logic      div_ready;
  avg_item_t div_item;

  jdaf_div #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_valid_q),
    .in_ready_o  (div_in_ready),
    .in_axis_i   (s2_axis_q),
    .in_sum_i    (s2_sum_q),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_item_o  (div_item)
  );

  // ---------------- byte framer ----------------
  jdaf_framer u_framer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (div_valid),
    .in_ready_o (div_ready),
    .in_item_i  (div_item),
    .out_o      (out_o)
  );

endmodule

@@ hdl/jdaf_checker.sv @@
// ----------------------------------------------------------------------------
// jdaf_checker
// port-level checks on the frame byte stream and the apb port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdaf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [jdaf_pkg::BYTE_W-1:0] out_byte_i,
  input logic                        frame_end_i,
  input logic                        pready_i
);
  import jdaf_pkg::*;

  logic [1:0] pos_q;
  logic       take;

  assign take = out_valid_i && out_ready_i;

  // position of the next byte within its frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
    end else if (take) begin
      pos_q <= pos_q + 2'd1;
    end
  end

  a_frame_end_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> (frame_end_i == (pos_q == 2'd3)))
    else $error("frame_end not on the fourth byte of a frame");

  a_high_byte_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && pos_q == 2'd2) |-> (out_byte_i == 8'h00 || out_byte_i == 8'hFF))
    else $error("high byte is not a sign extension");

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |-> pready_i)
    else $error("pready dropped");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_byte_i)))
    else $error("output item changed while stalled");

endmodule

bind joystick_deadzone_average_framer jdaf_checker u_jdaf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .frame_end_i (out_o.frame_end),
  .pready_i    (pready)
);
